@@ rtl/ldt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldt_pkg
// Shared types, constants and helpers of the linear directory table.
// ----------------------------------------------------------------------------
package ldt_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int NAME_BYTES_DEF = 8;

    localparam int OP_W  = 2;
    localparam int KEY_W = 64;
    localparam int PAY_W = 32;
    localparam int ST_W  = 2;
    localparam int CMP_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    start;
        logic    insert_wr;
        logic    scan;
        logic    move_rd;
        logic    move_wr;
        logic    finish;
        t_status fin_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic hit;
        logic exhausted;
        logic out_free;
    } t_stat;

    // Keeps the top name_bytes bytes up to the first zero byte; the rest is zero.
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] key,
                                                  input int name_bytes);
        logic [KEY_W-1:0] res;
        logic             stop;
        logic [7:0]       byte_v;
        res  = '0;
        stop = 1'b0;
        for (int b = 0; b < 8; b++) begin
            byte_v = key[KEY_W-1-8*b -: 8];
            if (b >= name_bytes || byte_v == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                res[KEY_W-1-8*b -: 8] = byte_v;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/ldt_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldt_req_if
// Request channel: one table operation per transaction.
// ----------------------------------------------------------------------------
interface ldt_req_if
    import ldt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] name_key;
    logic [PAY_W-1:0] entry_payload;

    modport source (output valid, output operation, output name_key,
                    output entry_payload, input ready);
    modport sink   (input valid, input operation, input name_key,
                    input entry_payload, output ready);
endinterface

@@ rtl/ldt_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldt_rsp_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
interface ldt_rsp_if
    import ldt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [PAY_W-1:0] found_payload;
    logic [CMP_W-1:0] comparison_count;

    modport source (output valid, output status, output found_payload,
                    output comparison_count, input ready);
    modport sink   (input valid, input status, input found_payload,
                    input comparison_count, output ready);
endinterface

@@ rtl/ldt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldt_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ldt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/ldt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldt_datapath
// Entry store, scan pointer, comparator, entry count and result register.
// ----------------------------------------------------------------------------
module ldt_datapath
    import ldt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [KEY_W-1:0] i_name_key,
    input  logic [PAY_W-1:0] i_entry_payload,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ST_W-1:0]  o_status,
    output logic [PAY_W-1:0] o_found_payload,
    output logic [CMP_W-1:0] o_comparison_count
);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int ENT_W  = KEY_W + PAY_W;

    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_comps;
    logic             r_pend;
    logic [CNT_W-1:0] r_pend_idx;
    logic [CNT_W-1:0] r_hit_idx;
    logic [PAY_W-1:0] r_found;

    logic             r_out_valid;
    t_status          r_status;
    logic [PAY_W-1:0] r_out_found;
    logic [CMP_W-1:0] r_out_comps;

    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] last_idx;
    logic             hit;
    logic             issue;

    assign last_idx = r_count - CNT_W'(1);
    assign hit      = r_pend && (ram_rdata[ENT_W-1 -: KEY_W] == r_key);
    assign issue    = i_cmd.scan && (r_idx != r_count) && !hit;

    always_comb begin
        ram_we    = i_cmd.insert_wr || i_cmd.move_wr;
        ram_waddr = i_cmd.move_wr ? r_hit_idx[ADDR_W-1:0] : r_count[ADDR_W-1:0];
        ram_wdata = i_cmd.move_wr ? ram_rdata : {r_key, r_pay};
        ram_re    = issue || i_cmd.move_rd;
        ram_raddr = i_cmd.move_rd ? last_idx[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    end

    ldt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_stat.op        = r_op;
        o_stat.full      = (r_count == CNT_W'(CAPACITY));
        o_stat.empty     = (r_count == '0);
        o_stat.hit       = hit;
        // The entry in compare is the last one and it did not match.
        o_stat.exhausted = r_pend && !hit && (r_idx == r_count);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // Control state of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= issue;
            if (i_cmd.insert_wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.move_wr) begin
                r_count <= last_idx;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= t_op'(i_operation);
            r_key   <= norm_key(i_name_key, NAME_BYTES);
            r_pay   <= i_entry_payload;
            r_idx   <= '0;
            r_comps <= '0;
            r_found <= '0;
        end else begin
            if (issue) begin
                r_idx      <= r_idx + CNT_W'(1);
                r_pend_idx <= r_idx;
            end
            if (i_cmd.scan && r_pend) begin
                r_comps <= r_comps + CNT_W'(1);
            end
            if (hit) begin
                r_hit_idx <= r_pend_idx;
                if (r_op == OP_LOOKUP) begin
                    r_found <= ram_rdata[PAY_W-1:0];
                end
            end
        end
        if (i_cmd.finish) begin
            r_status    <= i_cmd.fin_status;
            r_out_found <= r_found;
            r_out_comps <= CMP_W'(r_comps);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_found_payload    = r_out_found;
    assign o_comparison_count = r_out_comps;
endmodule

@@ rtl/ldt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldt_ctrl
// Sequencer for insert, lookup and delete.
// ----------------------------------------------------------------------------
module ldt_ctrl
    import ldt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_fin;
    t_status n_fin;

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.fin_status = r_fin;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            n_fin = ST_FULL;
                        end else begin
                            o_cmd.insert_wr = 1'b1;
                            n_fin           = ST_OK;
                        end
                    end
                    OP_LOOKUP, OP_DELETE: begin
                        n_fin = ST_MISS;
                        if (!i_stat.empty) begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_fin = ST_MISS;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_fin   = ST_OK;
                    n_state = (i_stat.op == OP_DELETE) ? S_MOVE_RD : S_FINISH;
                end else if (i_stat.exhausted) begin
                    n_fin   = ST_MISS;
                    n_state = S_FINISH;
                end
            end
            S_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // The last entry fills the hole left by the deleted one.
                o_cmd.move_wr = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= ST_MISS;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

@@ rtl/linear_directory_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_directory_table
// Unsorted name/payload table with linear-scan lookup and delete.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per transaction: insert appends the name and
//   payload, lookup returns the payload of the first matching name, delete
//   removes the first match and moves the last entry into its place.
//   o_rsp returns exactly one result per request: status, payload and the
//   number of name comparisons.
// Timing:
//   One request is in work at a time; the next is accepted the cycle after
//   the result is registered. Insert, unused codes and any lookup or delete
//   of an empty table go from decode straight to the finish state. Lookup
//   and delete scan the entries in order up to a match or the last entry;
//   delete then reads the last entry and writes it into the freed place.
//   One entry is read per cycle from the single read port of the entry RAM.
// Reset:
//   The entry count clears; the entry RAM is not cleared, since only entries
//   below the count are ever read.
// Stalls:
//   A result waits in the output register while o_rsp.ready is low; the
//   sequencer holds its finished result until that register frees up.
// ----------------------------------------------------------------------------
module linear_directory_table
    import ldt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ldt_req_if.sink      i_req,
    ldt_rsp_if.source    o_rsp
);
    t_cmd  cmd;
    t_stat stat;

    ldt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ldt_datapath #(
        .CAPACITY   (CAPACITY),
        .NAME_BYTES (NAME_BYTES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_operation        (i_req.operation),
        .i_name_key         (i_req.name_key),
        .i_entry_payload    (i_req.entry_payload),
        .o_out_valid        (o_rsp.valid),
        .i_out_ready        (o_rsp.ready),
        .o_status           (o_rsp.status),
        .o_found_payload    (o_rsp.found_payload),
        .o_comparison_count (o_rsp.comparison_count)
    );
endmodule

@@ verif/tb_linear_directory_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_directory_table
// Self-checking bench for the linear-scan directory table. It predicts
// status, payload and comparison count for every accepted request, and
// checks each response against the oldest prediction. The tests cover the
// empty table, field extremes, name padding, a full table and a long
// random mix, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_linear_directory_table
    import ldt_pkg::*;
();

    localparam int  CAP          = CAPACITY_DEF;
    localparam int  NBYTES       = NAME_BYTES_DEF;
    localparam int  CLK_HALF     = 10;
    localparam int  RANDOM_ITEMS = 580;
    localparam int  POOL_SIZE    = 20;
    localparam int  MAX_REPORTS  = 10;
    localparam int  TAIL_CYCLES  = 16;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;

    typedef struct {
        t_status          status;
        logic [PAY_W-1:0] payload;
        logic [CMP_W-1:0] comps;
    } t_dir_rsp;

    logic i_clk;
    logic i_rst_n;

    ldt_req_if req_if ();
    ldt_rsp_if rsp_if ();

    linear_directory_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the table contents.
    logic [KEY_W-1:0] mdl_names    [CAP];
    logic [PAY_W-1:0] mdl_payloads [CAP];
    int               mdl_count;

    t_dir_rsp         expected_rsp_q [$];
    int               fail_count;
    longint           cycle_count;
    bit               req_burst;
    bit               rsp_burst;

    logic [KEY_W-1:0] name_pool [POOL_SIZE];
    int               name_len  [POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Names compare as zero-terminated strings of at most NBYTES bytes.
    function automatic logic [KEY_W-1:0] canon_name(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] out;
        bit               keep;
        out  = '0;
        keep = 1'b1;
        for (int b = 7; b >= 0; b--) begin
            if (key[8*b +: 8] == 8'd0 || (7 - b) >= NBYTES) keep = 1'b0;
            if (keep) out[8*b +: 8] = key[8*b +: 8];
        end
        return out;
    endfunction

    function automatic t_dir_rsp dir_apply(input t_op op, input logic [KEY_W-1:0] key,
                                           input logic [PAY_W-1:0] pay);
        t_dir_rsp         r;
        logic [KEY_W-1:0] name;
        int               comps;
        bit               hit;
        name     = canon_name(key);
        r.status = ST_MISS;
        r.payload = '0;
        comps    = 0;
        hit      = 1'b0;
        case (op)
            OP_INSERT: begin
                if (mdl_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    mdl_names[mdl_count]    = name;
                    mdl_payloads[mdl_count] = pay;
                    mdl_count++;
                    r.status = ST_OK;
                end
            end
            OP_LOOKUP, OP_DELETE: begin
                for (int i = 0; i < mdl_count && !hit; i++) begin
                    comps++;
                    if (mdl_names[i] == name) begin
                        hit      = 1'b1;
                        r.status = ST_OK;
                        if (op == OP_LOOKUP) begin
                            r.payload = mdl_payloads[i];
                        end else begin
                            mdl_names[i]    = mdl_names[mdl_count-1];
                            mdl_payloads[i] = mdl_payloads[mdl_count-1];
                            mdl_count--;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.comps = CMP_W'(comps);
        return r;
    endfunction

    // Drives one request and returns at the edge where it is accepted.
    task automatic send_req(input t_op op, input logic [KEY_W-1:0] key,
                            input logic [PAY_W-1:0] pay);
        int gap;
        if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.name_key      <= key;
        req_if.entry_payload <= pay;
        do @(posedge i_clk); while (!req_if.ready);
        expected_rsp_q.push_back(dir_apply(op, key, pay));
    endtask

    function automatic logic [KEY_W-1:0] rand_key64();
        return {$urandom(), $urandom()};
    endfunction

    // A pool name, sometimes with junk after its terminating zero byte.
    function automatic logic [KEY_W-1:0] pool_key(input int idx, input bit junk);
        logic [KEY_W-1:0] mask;
        mask = '0;
        if (name_len[idx] <= 6) mask = (KEY_W'(1) << (56 - 8 * name_len[idx])) - 1;
        return junk ? (name_pool[idx] | (rand_key64() & mask)) : name_pool[idx];
    endfunction

    // Deleting the first entry always costs one comparison.
    task automatic empty_table();
        while (mdl_count > 0) send_req(OP_DELETE, mdl_names[0], $urandom());
    endtask

    task automatic test_empty_table();
        send_req(OP_LOOKUP, rand_key64(), $urandom());
        send_req(OP_DELETE, rand_key64(), $urandom());
        send_req(OP_NONE, rand_key64(), $urandom());
        send_req(OP_INSERT, 64'h5859_0000_0000_0000, 32'h0000_0001);
        send_req(OP_NONE, 64'h5859_0000_0000_0000, $urandom());
        send_req(OP_LOOKUP, 64'h5859_0000_0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_field_extremes();
        send_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_req(OP_INSERT, 64'h0000_0000_0000_0000, 32'h0000_0000);
        send_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        send_req(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_req(OP_LOOKUP, 64'h0000_0000_0000_0000, 32'hFFFF_FFFF);
        // A leading zero byte makes the whole name empty.
        send_req(OP_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 32'h0);
        send_req(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_req(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_req(OP_DELETE, 64'h0000_0000_0000_0000, 32'h0);
        send_req(OP_DELETE, 64'h0000_0000_0000_0000, 32'h0);
    endtask

    task automatic test_name_padding();
        send_req(OP_INSERT, 64'h4142_0000_0000_0000, 32'hA5A5_0001);
        send_req(OP_LOOKUP, 64'h4142_00FF_FFFF_FFFF, 32'h0);
        send_req(OP_LOOKUP, 64'h4142_4300_0000_0000, 32'h0);
        send_req(OP_INSERT, 64'h4142_0055_AA55_AA55, 32'h5A5A_0002);
        send_req(OP_DELETE, 64'h4142_0000_0000_0001, 32'h0);
        send_req(OP_LOOKUP, 64'h4142_0000_0000_0000, 32'h0);
        empty_table();
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] key;
        empty_table();
        for (int i = 0; mdl_count < CAP; i++) begin
            key = {8'h46, 1'b1, 7'(i >> 3), 5'b10101, 3'(i), 40'h5A_5A5A_5A5A};
            send_req(OP_INSERT, key, $urandom());
        end
        send_req(OP_INSERT, rand_key64(), 32'hFFFF_FFFF);
        send_req(OP_INSERT, 64'h0, 32'h0);
        send_req(OP_LOOKUP, mdl_names[CAP-1], 32'h0);
        send_req(OP_LOOKUP, 64'h4D49_5353_0000_0000, 32'h0);
        send_req(OP_LOOKUP, mdl_names[0], 32'h0);
        send_req(OP_DELETE, mdl_names[CAP/2], 32'h0);
        send_req(OP_INSERT, 64'h4C41_5354_0000_0000, 32'hC0DE_0001);
        send_req(OP_INSERT, 64'h4C41_5354_0000_0000, 32'hC0DE_0002);
        send_req(OP_DELETE, 64'h4D49_5353_0000_0000, 32'h0);
        empty_table();
    endtask

    task automatic test_random_mix();
        int               r;
        int               ins_pct;
        int               pick;
        t_op              op;
        logic [KEY_W-1:0] key;
        for (int p = 0; p < POOL_SIZE; p++) begin
            name_len[p]  = $urandom_range(0, 8);
            name_pool[p] = '0;
            for (int b = 0; b < name_len[p]; b++) begin
                name_pool[p][KEY_W-1-8*b -: 8] = 8'($urandom_range(1, 255));
            end
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Keep the table small so that scans stay short.
            ins_pct = (mdl_count >= 48) ? 10 : 42;
            r = $urandom_range(0, 99);
            if (r < ins_pct)   op = OP_INSERT;
            else if (r < 72)   op = OP_LOOKUP;
            else if (r < 96)   op = OP_DELETE;
            else               op = OP_NONE;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                key = rand_key64();
            else if (pick == 1 && mdl_count > 0 && op != OP_INSERT)
                key = mdl_names[$urandom_range(0, mdl_count - 1)];
            else
                key = pool_key($urandom_range(0, POOL_SIZE - 1), pick < 4);
            send_req(op, key, $urandom());
        end
    endtask

    initial begin : rsp_checker
        int       stall;
        t_dir_rsp want;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
            stall = rsp_burst ? 0 : $urandom_range(0, 17);
            @(negedge i_clk);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            if (expected_rsp_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected response: status %0d payload %h count %0d",
                             rsp_if.status, rsp_if.found_payload, rsp_if.comparison_count);
            end else begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.status !== want.status || rsp_if.found_payload !== want.payload ||
                    rsp_if.comparison_count !== want.comps) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: expected status %0d payload %h count %0d,",
                                  " got %0d %h %0d"},
                                 want.status, want.payload, want.comps, rsp_if.status,
                                 rsp_if.found_payload, rsp_if.comparison_count);
                end
            end
        end
    end

    initial begin
        fail_count           = 0;
        mdl_count            = 0;
        req_burst            = 1'b0;
        rsp_burst            = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.operation     = OP_NONE;
        req_if.name_key      = '0;
        req_if.entry_payload = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_name_padding();
        test_table_full();
        test_random_mix();

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_rsp_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
